// ===== design/bub_pkg.sv =====
// Shared types and constants for the upper-bound Bellman backup block.
package bub_pkg;

  localparam int VAL_W     = 32;  // Q16.16 values
  localparam int PROB_W    = 17;  // unsigned Q1.16 probability / discount
  localparam int ACC_W     = 56;  // Q24.32 accumulator
  localparam int IDX_W     = 4;   // reported action index
  localparam int LO_W      = 32;  // low part of accumulator for the discount pass
  localparam int HI_W      = ACC_W - LO_W;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 18;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int RND_W     = 17;  // (lo * d + half) >> 32 fits here
  localparam int Q_W       = 43;  // reward + discounted sum before saturation
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [PROB_W-1:0] DISCOUNT_RESET = 17'd62259;

  // register index decode: paddr[2]
  localparam logic CFG_IDX_DISCOUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_ACCUM,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_QSUM,
    ST_UPDATE
  } state_t;

  typedef enum logic [1:0] {
    MS_OUTCOME,
    MS_LO,
    MS_HI
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     rnd_en;
    logic     q_en;
    logic     upd_en;
  } ctrl_t;

endpackage

// ===== design/bub_if.sv =====
// Item channel interfaces: outcome input and backup result.
interface bub_in_if;
  logic                                valid;
  logic                                ready;
  logic                                outcome_present;
  logic        [bub_pkg::PROB_W-1:0]   outcome_prob;
  logic signed [bub_pkg::VAL_W-1:0]    successor_bound;
  logic signed [bub_pkg::VAL_W-1:0]    action_reward;
  logic signed [bub_pkg::VAL_W-1:0]    old_node_bound;
  logic                                last_outcome;
  logic                                last_action;

  modport source (output valid, outcome_present, outcome_prob, successor_bound,
                  action_reward, old_node_bound, last_outcome, last_action,
                  input ready);
  modport sink   (input valid, outcome_present, outcome_prob, successor_bound,
                  action_reward, old_node_bound, last_outcome, last_action,
                  output ready);
endinterface

interface bub_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bub_pkg::VAL_W-1:0]  q_value;
  logic        [bub_pkg::IDX_W-1:0]  action_index;
  logic                              node_done;
  logic signed [bub_pkg::VAL_W-1:0]  node_bound;
  logic        [bub_pkg::IDX_W-1:0]  best_action;

  modport source (output valid, q_value, action_index, node_done, node_bound,
                  best_action, input ready);
  modport sink   (input valid, q_value, action_index, node_done, node_bound,
                  best_action, output ready);
endinterface

// ===== design/bellman_upper_bound_backup_top.sv =====
// Top level: upper-bound Bellman backup with max-Q tracking per node.
//
//  channel | dir | handshake          | carries
//  --------+-----+--------------------+---------------------------------------
//  in_ch   | in  | valid/ready        | one successor outcome
//  out_ch  | out | valid/ready        | Q of a finished action, node bound
//  cfg     | in  | psel/penable/pready| discount register at byte address 0
//
//  An outcome that does not close its action goes through accept, product and
//  accumulate; an outcome with last_outcome then goes through the low and high
//  products of sum * discount, Q sum and update, plus any wait for the output
//  register. The single 33x18 multiplier runs the outcome, low and high products.
//  Reset (synchronous, rst_n low) clears the sequencer, the accumulator, the
//  node tracking and the output valid; discount returns to 0.95.
//  The output register lets the block take the next item while a result waits;
//  a second result stalls in the update step until the first is taken.
module bellman_upper_bound_backup_top #(
  parameter int MAX_ACTIONS  = 16,
  parameter int MAX_OUTCOMES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bub_in_if.sink                            in_ch,
  bub_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bub_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bub_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bub_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import bub_pkg::*;

  // action counter and outcome counter widths
  localparam int AW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
  localparam int OW = $clog2(MAX_OUTCOMES + 1);

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [MUL_P_W-1:0]      RND_HALF = MUL_P_W'(64'h8000_0000);

  ctrl_t             ctrl;
  logic [PROB_W-1:0] discount;
  logic              out_free;

  // captured item
  logic              add_en_r;
  logic [PROB_W-1:0] prob_r;
  logic signed [VAL_W-1:0] sb_r;
  logic signed [VAL_W-1:0] reward_r;
  logic signed [VAL_W-1:0] oldb_r;
  logic              last_out_r;
  logic              last_act_r;

  // accumulation and per-node state
  logic signed [ACC_W-1:0] sum_r;
  logic [OW-1:0]           ocnt_r;
  logic [AW-1:0]           acnt_r;
  logic signed [VAL_W-1:0] best_val_r;
  logic [AW-1:0]           best_idx_r;
  logic                    best_vld_r;

  // discount pipeline
  logic [RND_W-1:0]        rnd_r;
  logic signed [VAL_W-1:0] q_r;

  // output register
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] q_out_r;
  logic [IDX_W-1:0]        aidx_out_r;
  logic                    done_out_r;
  logic signed [VAL_W-1:0] nb_out_r;
  logic [IDX_W-1:0]        best_out_r;

  // shared multiplier operands
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p_r;

  logic signed [ACC_W:0]   sum_wide;
  logic signed [ACC_W-1:0] sum_sat;
  logic [MUL_P_W-1:0]      rnd_sum;
  logic signed [Q_W-1:0]   q_wide;
  logic signed [VAL_W-1:0] q_sat;
  logic                    better;
  logic signed [VAL_W-1:0] nbest_val;
  logic [AW-1:0]           nbest_idx;
  logic signed [VAL_W-1:0] node_bound;
  logic [AW+IDX_W-1:0]     acnt_ext;
  logic [AW+IDX_W-1:0]     bidx_ext;

  bub_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .discount (discount)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  bub_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .last_outcome (last_out_r),
    .out_free     (out_free),
    .ctrl         (ctrl)
  );

  assign in_ch.ready = ctrl.in_ready;

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl.mul_sel)
      MS_LO: begin
        mul_a = signed'({1'b0, sum_r[LO_W-1:0]});
        mul_b = signed'({1'b0, discount});
      end
      MS_HI: begin
        mul_a = MUL_A_W'(signed'(sum_r[ACC_W-1:LO_W]));
        mul_b = signed'({1'b0, discount});
      end
      default: begin
        mul_a = MUL_A_W'(sb_r);
        mul_b = signed'({1'b0, prob_r});
      end
    endcase
  end

  bub_mul u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p_r)
  );

  // saturating accumulate of prob * bound
  always_comb begin
    sum_wide = (ACC_W+1)'(sum_r) + (ACC_W+1)'(mul_p_r);
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  // low half rounded (tie toward +inf), then Q = reward + hi*d + round
  assign rnd_sum = mul_p_r + RND_HALF;

  always_comb begin
    q_wide = Q_W'(mul_p_r) + Q_W'(signed'({1'b0, rnd_r})) + Q_W'(reward_r);
    if (q_wide > Q_W'(VAL_MAX)) begin
      q_sat = VAL_MAX;
    end else if (q_wide < Q_W'(VAL_MIN)) begin
      q_sat = VAL_MIN;
    end else begin
      q_sat = q_wide[VAL_W-1:0];
    end
  end

  // best-Q tracking; first action of a node always wins, ties keep earlier
  always_comb begin
    better    = !best_vld_r || (q_r > best_val_r);
    nbest_val = better ? q_r : best_val_r;
    nbest_idx = better ? acnt_r : best_idx_r;
    node_bound = (oldb_r < nbest_val) ? oldb_r : nbest_val;
    acnt_ext  = {{IDX_W{1'b0}}, acnt_r};
    bidx_ext  = {{IDX_W{1'b0}}, nbest_idx};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prob_r     <= in_ch.outcome_prob;
      sb_r       <= in_ch.successor_bound;
      reward_r   <= in_ch.action_reward;
      oldb_r     <= in_ch.old_node_bound;
      last_out_r <= in_ch.last_outcome;
      last_act_r <= in_ch.last_action;
      add_en_r   <= in_ch.outcome_present && (ocnt_r < OW'(MAX_OUTCOMES));
    end
    if (ctrl.rnd_en) begin
      rnd_r <= rnd_sum[LO_W +: RND_W];
    end
    if (ctrl.q_en) begin
      q_r <= q_sat;
    end
    if (ctrl.upd_en) begin
      q_out_r    <= q_r;
      aidx_out_r <= acnt_ext[IDX_W-1:0];
      done_out_r <= last_act_r;
      nb_out_r   <= last_act_r ? node_bound : '0;
      best_out_r <= last_act_r ? bidx_ext[IDX_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      ocnt_r      <= '0;
      acnt_r      <= '0;
      best_val_r  <= VAL_MIN;
      best_idx_r  <= '0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.load && (ocnt_r < OW'(MAX_OUTCOMES))) begin
        ocnt_r <= ocnt_r + OW'(1);
      end
      if (ctrl.acc_en && add_en_r) begin
        sum_r <= sum_sat;
      end
      if (ctrl.upd_en) begin
        sum_r  <= '0;
        ocnt_r <= '0;
        if (last_act_r) begin
          acnt_r     <= '0;
          best_val_r <= VAL_MIN;
          best_idx_r <= '0;
          best_vld_r <= 1'b0;
        end else begin
          acnt_r     <= (acnt_r == AW'(MAX_ACTIONS - 1)) ? '0 : acnt_r + AW'(1);
          best_val_r <= nbest_val;
          best_idx_r <= nbest_idx;
          best_vld_r <= 1'b1;
        end
      end
      if (ctrl.upd_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.q_value      = q_out_r;
  assign out_ch.action_index = aidx_out_r;
  assign out_ch.node_done    = done_out_r;
  assign out_ch.node_bound   = nb_out_r;
  assign out_ch.best_action  = best_out_r;

endmodule

// ===== design/bub_mul.sv =====
// Shared signed multiplier with registered product.
module bub_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [bub_pkg::MUL_A_W-1:0]  a,
  input  logic signed [bub_pkg::MUL_B_W-1:0]  b,
  output logic signed [bub_pkg::MUL_P_W-1:0]  p_r
);
  import bub_pkg::*;

  logic signed [MUL_P_W-1:0] p_nxt;

  assign p_nxt = MUL_P_W'(a) * MUL_P_W'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end
endmodule

// ===== design/bub_cfg.sv =====
// APB-style register file: discount factor.
module bub_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bub_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bub_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [bub_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [bub_pkg::PROB_W-1:0]         discount
);
  import bub_pkg::*;

  logic [PROB_W-1:0] discount_r;
  logic              wr_en;
  logic              hit;

  assign pready   = 1'b1;
  assign hit      = (paddr[2] == CFG_IDX_DISCOUNT);
  assign wr_en    = psel && penable && pwrite && hit;
  assign discount = discount_r;
  assign prdata   = hit ? CFG_DATA_W'(discount_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discount_r <= DISCOUNT_RESET;
    end else if (wr_en) begin
      discount_r <= pwdata[PROB_W-1:0];
    end
  end
endmodule

// ===== design/bub_ctrl.sv =====
// Sequencer: steps one item through the shared multiplier.
module bub_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            last_outcome,
  input  logic            out_free,
  output bub_pkg::ctrl_t  ctrl
);
  import bub_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_PROD;
      ST_PROD:   state_nxt = ST_ACCUM;
      ST_ACCUM:  state_nxt = last_outcome ? ST_MUL_LO : ST_IDLE;
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_QSUM;
      ST_QSUM:   state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = MS_OUTCOME;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.load     = in_valid;
      end
      ST_PROD: begin
        ctrl.mul_en = 1'b1;
      end
      ST_ACCUM: begin
        ctrl.acc_en = 1'b1;
      end
      ST_MUL_LO: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_LO;
      end
      ST_MUL_HI: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_HI;
        ctrl.rnd_en  = 1'b1;
      end
      ST_QSUM: begin
        ctrl.q_en = 1'b1;
      end
      ST_UPDATE: begin
        ctrl.upd_en = out_free;
      end
      default: ctrl = '0;
    endcase
  end
endmodule

// ===== design/bub_chk.sv =====
// Port-level checker for the backup block, bound to the top level.
module bub_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [bub_pkg::VAL_W-1:0] out_q_value,
  input logic                            out_node_done,
  input logic signed [bub_pkg::VAL_W-1:0] out_node_bound,
  input logic [bub_pkg::IDX_W-1:0]       out_best_action
);
  import bub_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_q_value))
    else $error("result dropped or changed while stalled");

  // block is busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted back to back");

  // a new result appears only after work with input closed
  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while idle");

  // node fields are zero unless the node closes
  a_node_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_node_done |-> (out_node_bound == '0) && (out_best_action == '0))
    else $error("node fields set on a non-closing result");
endmodule

bind bellman_upper_bound_backup_top bub_chk u_bub_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_q_value     (out_ch.q_value),
  .out_node_done   (out_ch.node_done),
  .out_node_bound  (out_ch.node_bound),
  .out_best_action (out_ch.best_action)
);
